// File: sv/bcdclk_pkg.sv
// Package for the BCD time-of-day clock: event and button codes, digit
// limits, reset time and the small digit helpers. No dependencies.
package bcdclk_pkg;

  // Event kinds carried in the func field
  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_BUTTON = 2'd1,
    FUNC_LOAD   = 2'd2
  } func_e;

  // Buttons for a button event
  typedef enum logic [1:0] {
    BTN_UP    = 2'd0,
    BTN_DOWN  = 2'd1,
    BTN_LEFT  = 2'd2,
    BTN_RIGHT = 2'd3
  } button_e;

  // Digit selected for editing
  typedef enum logic [2:0] {
    DIG_HOUR_TENS = 3'd0,
    DIG_HOUR_ONES = 3'd1,
    DIG_MIN_TENS  = 3'd2,
    DIG_MIN_ONES  = 3'd3,
    DIG_SEC_TENS  = 3'd4,
    DIG_SEC_ONES  = 3'd5
  } digit_e;

  // Mode bit
  localparam logic MODE_RUN = 1'b0;
  localparam logic MODE_SET = 1'b1;

  // Digit limits
  localparam logic [3:0] LIM_HOUR_TENS    = 4'd2;
  localparam logic [3:0] LIM_HOUR_ONES_HI = 4'd3;  // when hour tens is 2
  localparam logic [3:0] LIM_ONES         = 4'd9;
  localparam logic [3:0] LIM_TENS         = 4'd5;

  // Carry thresholds
  localparam logic [3:0] ONES_WRAP      = 4'd10;
  localparam logic [2:0] TENS_WRAP      = 3'd6;
  localparam logic [3:0] HOUR_ONES_WRAP = 4'd4;   // with hour tens 2
  localparam logic [1:0] HOUR_TENS_TOP  = 2'd2;

  // Load saturation
  localparam logic [4:0] MAX_HOUR = 5'd23;
  localparam logic [5:0] MAX_MS   = 6'd59;

  // Reset time 12:30:00
  localparam logic [1:0] RST_HOUR_TENS = 2'd1;
  localparam logic [3:0] RST_HOUR_ONES = 4'd2;
  localparam logic [2:0] RST_MIN_TENS  = 3'd3;
  localparam logic [3:0] RST_MIN_ONES  = 4'd0;
  localparam logic [2:0] RST_SEC_TENS  = 3'd0;
  localparam logic [3:0] RST_SEC_ONES  = 4'd0;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } dec_t;

  // Step a digit up or down with wrap inside 0..lim
  function automatic logic [3:0] step_digit(logic [3:0] v, logic [3:0] lim, logic up);
    logic [3:0] r;
    if (up) begin
      r = (v < lim) ? v + 4'd1 : 4'd0;
    end else begin
      r = (v > 4'd0) ? v - 4'd1 : lim;
    end
    return r;
  endfunction

  // Split a value of at most 59 into tens and ones by compares
  function automatic dec_t dec_split(logic [5:0] v);
    dec_t r;
    logic [5:0] base;
    if (v >= 6'd50) begin
      r.tens = 3'd5;
    end else if (v >= 6'd40) begin
      r.tens = 3'd4;
    end else if (v >= 6'd30) begin
      r.tens = 3'd3;
    end else if (v >= 6'd20) begin
      r.tens = 3'd2;
    end else if (v >= 6'd10) begin
      r.tens = 3'd1;
    end else begin
      r.tens = 3'd0;
    end
    base   = {r.tens, 3'b000} + {2'b00, r.tens, 1'b0};  // tens * 10
    r.ones = 4'(v - base);
    return r;
  endfunction

endpackage

// File: sv/bcdclk_in_if.sv
// Event channel of the BCD clock: valid/ready handshake with event payload.
// Depends on nothing.
interface bcdclk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] button;
  logic [4:0] load_hour;
  logic [5:0] load_minute;
  logic [5:0] load_second;

  modport source (output valid, func, button, load_hour, load_minute, load_second,
                  input ready);
  modport sink   (input valid, func, button, load_hour, load_minute, load_second,
                  output ready);
endinterface

// File: sv/bcdclk_out_if.sv
// Result channel of the BCD clock: valid/ready handshake with time digits,
// mode and selected digit. Depends on nothing.
interface bcdclk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] hour_tens;
  logic [3:0] hour_ones;
  logic [2:0] minute_tens;
  logic [3:0] minute_ones;
  logic [2:0] second_tens;
  logic [3:0] second_ones;
  logic       setting_mode;
  logic [2:0] selected_digit;

  modport source (output valid, hour_tens, hour_ones, minute_tens, minute_ones,
                         second_tens, second_ones, setting_mode, selected_digit,
                  input ready);
  modport sink   (input valid, hour_tens, hour_ones, minute_tens, minute_ones,
                        second_tens, second_ones, setting_mode, selected_digit,
                  output ready);
endinterface

// File: sv/bcd_clock_with_digit_set_core.sv
// BCD 24-hour clock with set mode. An accepted word updates the time
// registers, which drive the result. Throughput: one word per cycle;
// the time registers double as the result register, so a new word is taken
// whenever the result is empty or being taken in the same cycle.
// Reset (rst_ni low, async): time 12:30:00, run mode, hour tens selected,
// no result pending. Uses bcdclk_pkg, bcdclk_in_if and bcdclk_out_if.
module bcd_clock_with_digit_set_core (
  input  logic  clk_i,
  input  logic  rst_ni,
  bcdclk_in_if.sink    in_i,
  bcdclk_out_if.source out_o
);

  logic [1:0] ht_q, ht_d;
  logic [3:0] ho_q, ho_d;
  logic [2:0] mt_q, mt_d;
  logic [3:0] mo_q, mo_d;
  logic [2:0] st_q, st_d;
  logic [3:0] so_q, so_d;
  logic       mode_q, mode_d;
  logic [2:0] sel_q, sel_d;
  logic       out_valid_q, out_valid_d;

  logic       in_ready;
  logic       accept;

  // Handshake: take a word when the result slot is free or drains now
  assign in_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Tick carry chain
  logic [3:0] so_inc, mo_inc, ho_inc;
  logic [2:0] st_inc, mt_inc;
  logic       so_wrap, st_wrap, mo_wrap, mt_wrap;
  logic [1:0] ht_tick;
  logic [3:0] ho_tick;

  assign so_inc  = so_q + 4'd1;
  assign st_inc  = st_q + 3'd1;
  assign mo_inc  = mo_q + 4'd1;
  assign mt_inc  = mt_q + 3'd1;
  assign ho_inc  = ho_q + 4'd1;
  assign so_wrap = (so_inc >= bcdclk_pkg::ONES_WRAP);
  assign st_wrap = so_wrap && (st_inc >= bcdclk_pkg::TENS_WRAP);
  assign mo_wrap = st_wrap && (mo_inc >= bcdclk_pkg::ONES_WRAP);
  assign mt_wrap = mo_wrap && (mt_inc >= bcdclk_pkg::TENS_WRAP);

  // Hour update on a minute-tens carry
  always_comb begin
    ht_tick = ht_q;
    ho_tick = ho_inc;
    if (ht_q >= bcdclk_pkg::HOUR_TENS_TOP) begin
      if (ho_inc >= bcdclk_pkg::HOUR_ONES_WRAP) begin
        ho_tick = 4'd0;
        ht_tick = 2'd0;
      end
    end else if (ho_inc >= bcdclk_pkg::ONES_WRAP) begin
      ho_tick = 4'd0;
      ht_tick = ht_q + 2'd1;
    end
  end

  // Load: saturate and split into digits
  logic [4:0]       hour_sat;
  logic [5:0]       min_sat, sec_sat;
  bcdclk_pkg::dec_t hour_dec, min_dec, sec_dec;

  assign hour_sat = (in_i.load_hour > bcdclk_pkg::MAX_HOUR) ? bcdclk_pkg::MAX_HOUR
                                                            : in_i.load_hour;
  assign min_sat  = (in_i.load_minute > bcdclk_pkg::MAX_MS) ? bcdclk_pkg::MAX_MS
                                                            : in_i.load_minute;
  assign sec_sat  = (in_i.load_second > bcdclk_pkg::MAX_MS) ? bcdclk_pkg::MAX_MS
                                                            : in_i.load_second;
  assign hour_dec = bcdclk_pkg::dec_split({1'b0, hour_sat});
  assign min_dec  = bcdclk_pkg::dec_split(min_sat);
  assign sec_dec  = bcdclk_pkg::dec_split(sec_sat);

  // Edit: step the selected digit; left steps up, right steps down
  logic       edit_up;
  logic [3:0] ho_lim;

  assign edit_up = (bcdclk_pkg::button_e'(in_i.button) == bcdclk_pkg::BTN_LEFT);
  assign ho_lim  = (ht_q == bcdclk_pkg::HOUR_TENS_TOP) ? bcdclk_pkg::LIM_HOUR_ONES_HI
                                                        : bcdclk_pkg::LIM_ONES;

  // Next state for one accepted word
  always_comb begin
    ht_d   = ht_q;
    ho_d   = ho_q;
    mt_d   = mt_q;
    mo_d   = mo_q;
    st_d   = st_q;
    so_d   = so_q;
    mode_d = mode_q;
    sel_d  = sel_q;
    if (accept) begin
      if (mode_q == bcdclk_pkg::MODE_RUN) begin
        unique case (bcdclk_pkg::func_e'(in_i.func))
          bcdclk_pkg::FUNC_TICK: begin
            so_d = so_wrap ? 4'd0 : so_inc;
            if (so_wrap) st_d = st_wrap ? 3'd0 : st_inc;
            if (st_wrap) mo_d = mo_wrap ? 4'd0 : mo_inc;
            if (mo_wrap) mt_d = mt_wrap ? 3'd0 : mt_inc;
            if (mt_wrap) begin
              ho_d = ho_tick;
              ht_d = ht_tick;
            end
          end
          bcdclk_pkg::FUNC_BUTTON: begin
            if (bcdclk_pkg::button_e'(in_i.button) == bcdclk_pkg::BTN_DOWN) begin
              mode_d = bcdclk_pkg::MODE_SET;
            end
          end
          bcdclk_pkg::FUNC_LOAD: begin
            ht_d = hour_dec.tens[1:0];
            ho_d = hour_dec.ones;
            mt_d = min_dec.tens;
            mo_d = min_dec.ones;
            st_d = sec_dec.tens;
            so_d = sec_dec.ones;
          end
          default: ;
        endcase
      end else if (bcdclk_pkg::func_e'(in_i.func) == bcdclk_pkg::FUNC_BUTTON) begin
        unique case (bcdclk_pkg::button_e'(in_i.button))
          bcdclk_pkg::BTN_UP: begin
            sel_d = (sel_q >= bcdclk_pkg::DIG_SEC_ONES) ? bcdclk_pkg::DIG_HOUR_TENS
                                                        : sel_q + 3'd1;
          end
          bcdclk_pkg::BTN_DOWN: begin
            mode_d = bcdclk_pkg::MODE_RUN;
            sel_d  = bcdclk_pkg::DIG_HOUR_TENS;
          end
          default: begin
            unique case (bcdclk_pkg::digit_e'(sel_q))
              bcdclk_pkg::DIG_HOUR_TENS:
                ht_d = 2'(bcdclk_pkg::step_digit({2'b00, ht_q},
                                                 bcdclk_pkg::LIM_HOUR_TENS, edit_up));
              bcdclk_pkg::DIG_HOUR_ONES:
                ho_d = bcdclk_pkg::step_digit(ho_q, ho_lim, edit_up);
              bcdclk_pkg::DIG_MIN_TENS:
                mt_d = 3'(bcdclk_pkg::step_digit({1'b0, mt_q},
                                                 bcdclk_pkg::LIM_TENS, edit_up));
              bcdclk_pkg::DIG_MIN_ONES:
                mo_d = bcdclk_pkg::step_digit(mo_q, bcdclk_pkg::LIM_ONES, edit_up);
              bcdclk_pkg::DIG_SEC_TENS:
                st_d = 3'(bcdclk_pkg::step_digit({1'b0, st_q},
                                                 bcdclk_pkg::LIM_TENS, edit_up));
              bcdclk_pkg::DIG_SEC_ONES:
                so_d = bcdclk_pkg::step_digit(so_q, bcdclk_pkg::LIM_ONES, edit_up);
              default: ;
            endcase
          end
        endcase
      end
    end
  end

  // Result slot: filled on accept, emptied when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ht_q        <= bcdclk_pkg::RST_HOUR_TENS;
      ho_q        <= bcdclk_pkg::RST_HOUR_ONES;
      mt_q        <= bcdclk_pkg::RST_MIN_TENS;
      mo_q        <= bcdclk_pkg::RST_MIN_ONES;
      st_q        <= bcdclk_pkg::RST_SEC_TENS;
      so_q        <= bcdclk_pkg::RST_SEC_ONES;
      mode_q      <= bcdclk_pkg::MODE_RUN;
      sel_q       <= bcdclk_pkg::DIG_HOUR_TENS;
      out_valid_q <= 1'b0;
    end else begin
      ht_q        <= ht_d;
      ho_q        <= ho_d;
      mt_q        <= mt_d;
      mo_q        <= mo_d;
      st_q        <= st_d;
      so_q        <= so_d;
      mode_q      <= mode_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result word straight from the state
  assign out_o.valid          = out_valid_q;
  assign out_o.hour_tens      = ht_q;
  assign out_o.hour_ones      = ho_q;
  assign out_o.minute_tens    = mt_q;
  assign out_o.minute_ones    = mo_q;
  assign out_o.second_tens    = st_q;
  assign out_o.second_ones    = so_q;
  assign out_o.setting_mode   = mode_q;
  assign out_o.selected_digit = sel_q;

  // Checks
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word left no result");

  a_state_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable({ht_q, ho_q, mt_q, mo_q, st_q, so_q})
                                       && $stable(sel_q) && $stable(mode_q)))
    else $error("state changed while result stalled");

  a_run_selects_hour_tens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == bcdclk_pkg::MODE_RUN) |-> (sel_q == bcdclk_pkg::DIG_HOUR_TENS))
    else $error("digit selected while running");

  a_digits_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ht_q <= bcdclk_pkg::HOUR_TENS_TOP) && (sel_q <= bcdclk_pkg::DIG_SEC_ONES)
    && (so_q <= bcdclk_pkg::LIM_ONES) && (mo_q <= bcdclk_pkg::LIM_ONES))
    else $error("digit out of range");

endmodule

// File: test/bcd_clock_with_digit_set_core_tb.sv
// Testbench for bcd_clock_with_digit_set_core: directed and random event words
// checked against an in-bench model of the 24-hour BCD clock.
// Depends on bcdclk_pkg, bcdclk_in_if, bcdclk_out_if and the core itself.
module bcd_clock_with_digit_set_core_tb;

  // Event code with no meaning; the core must leave its state alone
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int RANDOM_WORDS   = 1900;
  localparam int WATCHDOG_LIMIT = 400;

  typedef struct {
    logic [1:0]          func;
    bcdclk_pkg::button_e button;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
    bit                  wait_idle;  // hold this word until every readout is back
  } clock_event_t;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
    logic       mode;
    logic [2:0] digit;
  } readout_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  bcdclk_in_if  ev_if ();
  bcdclk_out_if rd_if ();

  bcd_clock_with_digit_set_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ev_if),
    .out_o  (rd_if)
  );

  clock_event_t event_q[$];    // words waiting to be driven
  readout_t     readout_q[$];  // expected readouts, oldest first
  clock_event_t sent_event;
  readout_t     model_rd;      // model of the clock registers
  int           failures = 0;
  int           gap_left;
  int           stall_left;
  int           idle_cycles = 0;
  bit           calm_in = 1'b0;
  bit           calm_out = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [3:0] wrap_step(logic [3:0] v, logic [3:0] top, bit inc);
    if (inc) return (v >= top) ? 4'd0 : v + 4'd1;
    return (v == 4'd0) ? top : v - 4'd1;
  endfunction

  // One-second tick with BCD carries; 23:59:59 rolls to 00:00:00
  function automatic void advance_second();
    model_rd.sec_ones += 4'd1;
    if (model_rd.sec_ones < 4'd10) return;
    model_rd.sec_ones = 4'd0;
    model_rd.sec_tens += 3'd1;
    if (model_rd.sec_tens < 3'd6) return;
    model_rd.sec_tens = 3'd0;
    model_rd.min_ones += 4'd1;
    if (model_rd.min_ones < 4'd10) return;
    model_rd.min_ones = 4'd0;
    model_rd.min_tens += 3'd1;
    if (model_rd.min_tens < 3'd6) return;
    model_rd.min_tens = 3'd0;
    model_rd.hour_ones += 4'd1;
    if (model_rd.hour_tens >= 2'd2) begin
      // also catches hours like 29 left over from set mode
      if (model_rd.hour_ones >= 4'd4) begin
        model_rd.hour_ones = 4'd0;
        model_rd.hour_tens = 2'd0;
      end
    end else if (model_rd.hour_ones >= 4'd10) begin
      model_rd.hour_ones = 4'd0;
      model_rd.hour_tens += 2'd1;
    end
  endfunction

  // Load with saturation, then split into decimal digits
  function automatic void load_time(clock_event_t ev);
    int h, m, s;
    h = (ev.hour > 5'd23) ? 23 : int'(ev.hour);
    m = (ev.minute > 6'd59) ? 59 : int'(ev.minute);
    s = (ev.second > 6'd59) ? 59 : int'(ev.second);
    model_rd.hour_tens = 2'(h / 10);
    model_rd.hour_ones = 4'(h % 10);
    model_rd.min_tens  = 3'(m / 10);
    model_rd.min_ones  = 4'(m % 10);
    model_rd.sec_tens  = 3'(s / 10);
    model_rd.sec_ones  = 4'(s % 10);
  endfunction

  function automatic void step_selected(bit inc);
    case (model_rd.digit)
      bcdclk_pkg::DIG_HOUR_TENS:
        model_rd.hour_tens = 2'(wrap_step(4'(model_rd.hour_tens), 4'd2, inc));
      bcdclk_pkg::DIG_HOUR_ONES:
        model_rd.hour_ones = wrap_step(model_rd.hour_ones,
                                       (model_rd.hour_tens == 2'd2) ? 4'd3 : 4'd9, inc);
      bcdclk_pkg::DIG_MIN_TENS:
        model_rd.min_tens = 3'(wrap_step(4'(model_rd.min_tens), 4'd5, inc));
      bcdclk_pkg::DIG_MIN_ONES:
        model_rd.min_ones = wrap_step(model_rd.min_ones, 4'd9, inc);
      bcdclk_pkg::DIG_SEC_TENS:
        model_rd.sec_tens = 3'(wrap_step(4'(model_rd.sec_tens), 4'd5, inc));
      bcdclk_pkg::DIG_SEC_ONES:
        model_rd.sec_ones = wrap_step(model_rd.sec_ones, 4'd9, inc);
      default: ;
    endcase
  endfunction

  // Apply one event word and return the readout it should produce
  function automatic readout_t apply_event(clock_event_t ev);
    if (model_rd.mode == bcdclk_pkg::MODE_RUN) begin
      case (ev.func)
        bcdclk_pkg::FUNC_TICK:   advance_second();
        bcdclk_pkg::FUNC_BUTTON:
          if (ev.button == bcdclk_pkg::BTN_DOWN) model_rd.mode = bcdclk_pkg::MODE_SET;
        bcdclk_pkg::FUNC_LOAD:   load_time(ev);
        default: ;
      endcase
    end else if (ev.func == bcdclk_pkg::FUNC_BUTTON) begin
      case (ev.button)
        bcdclk_pkg::BTN_UP:
          model_rd.digit = (model_rd.digit >= bcdclk_pkg::DIG_SEC_ONES)
                           ? bcdclk_pkg::DIG_HOUR_TENS : model_rd.digit + 3'd1;
        bcdclk_pkg::BTN_DOWN: begin
          model_rd.mode  = bcdclk_pkg::MODE_RUN;
          model_rd.digit = bcdclk_pkg::DIG_HOUR_TENS;
        end
        bcdclk_pkg::BTN_LEFT: step_selected(1'b1);
        default:  step_selected(1'b0);
      endcase
    end
    return model_rd;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic clock_event_t ev_of(logic [1:0] func, bcdclk_pkg::button_e button,
                                         int h, int m, int s, bit wait_idle);
    clock_event_t ev;
    ev.func      = func;
    ev.button    = button;
    ev.hour      = 5'(h);
    ev.minute    = 6'(m);
    ev.second    = 6'(s);
    ev.wait_idle = wait_idle;
    return ev;
  endfunction

  // Mostly well-formed events, biased toward loads just short of a rollover
  function automatic clock_event_t random_event();
    clock_event_t ev;
    int pick;
    ev = ev_of(bcdclk_pkg::FUNC_TICK, bcdclk_pkg::button_e'(2'($urandom_range(0, 3))),
               $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 99) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      ev.func = bcdclk_pkg::FUNC_TICK;
    end else if (pick < 75) begin
      ev.func = bcdclk_pkg::FUNC_BUTTON;
      if ($urandom_range(0, 99) < 15) ev.button = bcdclk_pkg::BTN_DOWN;
      else ev.button = bcdclk_pkg::button_e'(2'($urandom_range(0, 3)));
    end else if (pick < 95) begin
      ev.func = bcdclk_pkg::FUNC_LOAD;
      case ($urandom_range(0, 3))
        0: ;  // full field range, saturation included
        1: begin
          ev.hour   = 5'($urandom_range(0, 23));
          ev.minute = 6'($urandom_range(0, 59));
          ev.second = 6'($urandom_range(0, 59));
        end
        default: begin
          case ($urandom_range(0, 3))
            0: ev.hour = 5'd9;
            1: ev.hour = 5'd19;
            2: ev.hour = 5'd23;
            default: ev.hour = 5'($urandom_range(0, 23));
          endcase
          ev.minute = 6'($urandom_range(58, 59));
          ev.second = 6'($urandom_range(50, 59));
        end
      endcase
    end else begin
      ev.func = FUNC_NONE;
    end
    return ev;
  endfunction

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [3:0] expv, logic [3:0] actv);
    if (actv !== expv) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
    end
  endfunction

  function automatic void check_readout(readout_t exp_rd);
    check_field("hour_tens", 4'(exp_rd.hour_tens), 4'(rd_if.hour_tens));
    check_field("hour_ones", exp_rd.hour_ones, rd_if.hour_ones);
    check_field("minute_tens", 4'(exp_rd.min_tens), 4'(rd_if.minute_tens));
    check_field("minute_ones", exp_rd.min_ones, rd_if.minute_ones);
    check_field("second_tens", 4'(exp_rd.sec_tens), 4'(rd_if.second_tens));
    check_field("second_ones", exp_rd.sec_ones, rd_if.second_ones);
    check_field("setting_mode", 4'(exp_rd.mode), 4'(rd_if.setting_mode));
    check_field("selected_digit", 4'(exp_rd.digit), 4'(rd_if.selected_digit));
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_if.valid       <= 1'b0;
      ev_if.func        <= bcdclk_pkg::FUNC_TICK;
      ev_if.button      <= bcdclk_pkg::BTN_UP;
      ev_if.load_hour   <= '0;
      ev_if.load_minute <= '0;
      ev_if.load_second <= '0;
      gap_left = 0;
      // reset time 12:30:00, running, hour tens selected
      model_rd = '{hour_tens: 2'd1, hour_ones: 4'd2, min_tens: 3'd3, min_ones: 4'd0,
                   sec_tens: 3'd0, sec_ones: 4'd0, mode: bcdclk_pkg::MODE_RUN,
                   digit: bcdclk_pkg::DIG_HOUR_TENS};
    end else begin
      if (ev_if.valid && ev_if.ready) begin
        readout_q.push_back(apply_event(sent_event));
        gap_left = draw_wait(calm_in);
      end
      if (!ev_if.valid || ev_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          ev_if.valid <= 1'b0;
        end else if (event_q.size() != 0 &&
                     !(event_q[0].wait_idle && (readout_q.size() != 0 || rd_if.valid))) begin
          sent_event = event_q.pop_front();
          ev_if.valid       <= 1'b1;
          ev_if.func        <= sent_event.func;
          ev_if.button      <= sent_event.button;
          ev_if.load_hour   <= sent_event.hour;
          ev_if.load_minute <= sent_event.minute;
          ev_if.load_second <= sent_event.second;
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rd_if.valid && rd_if.ready) begin
        if (readout_q.size() == 0) begin
          failures++;
          $display("%0t: extra readout word, expected nothing, got %0d%0d:%0d%0d:%0d%0d",
                   $time, rd_if.hour_tens, rd_if.hour_ones, rd_if.minute_tens,
                   rd_if.minute_ones, rd_if.second_tens, rd_if.second_ones);
        end else begin
          check_readout(readout_q.pop_front());
        end
        stall_left = draw_wait(calm_out);
      end
      if (stall_left > 0) begin
        stall_left--;
        rd_if.ready <= 1'b0;
      end else begin
        rd_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without a word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (ev_if.valid && ev_if.ready) || (rd_if.valid && rd_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int count;
    int run;
    rst_ni <= 1'b0;

    // directed: carries, saturation, ignored events and set-mode edits
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_TICK,   bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(FUNC_NONE,               bcdclk_pkg::BTN_DOWN, 31, 63, 63, 1'b0));
    // saturates
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_LOAD,   bcdclk_pkg::BTN_UP,   31, 63, 63, 1'b0));
    // midnight
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_TICK,   bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_LOAD,   bcdclk_pkg::BTN_UP,    9, 59, 59, 1'b0));
    // 09 -> 10
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_TICK,   bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_LOAD,   bcdclk_pkg::BTN_UP,   19, 59, 59, 1'b0));
    // ignored in run
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_LEFT,  0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_RIGHT, 0,  0,  0, 1'b0));
    // enter set mode
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_DOWN,  0,  0,  0, 1'b1));
    // ignored in set
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_TICK,   bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_LOAD,   bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(FUNC_NONE,               bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    // 19 -> 29, then tens wraps to 0, then back to 29
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_LEFT,  0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_LEFT,  0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_RIGHT, 0,  0,  0, 1'b0));
    // hour ones, then 29 -> 28
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_RIGHT, 0,  0,  0, 1'b0));
    // back to run
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_DOWN,  0,  0,  0, 1'b0));
    // 28:59:59 wraps
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_TICK,   bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_DOWN,  0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_UP,    0,  0,  0, 1'b0));
    event_q.push_back(ev_of(bcdclk_pkg::FUNC_BUTTON, bcdclk_pkg::BTN_LEFT,  0,  0,  0, 1'b1));

    // random: single events plus runs of ticks to reach the deeper carries
    count = 0;
    while (count < RANDOM_WORDS) begin
      if ($urandom_range(0, 19) == 0) begin
        run = $urandom_range(5, 70);
        repeat (run) begin
          event_q.push_back(ev_of(bcdclk_pkg::FUNC_TICK, bcdclk_pkg::BTN_UP, 0, 0, 0, 1'b0));
        end
        count += run;
      end else begin
        event_q.push_back(random_event());
        count++;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample between edges so driver and monitor updates have settled
    do @(negedge clk_i);
    while (event_q.size() != 0 || ev_if.valid || readout_q.size() != 0);
    repeat (4) @(posedge clk_i);

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
